[src/qsu_pkg.sv]
// ----------------------------------------------------------------------------
// qsu_pkg: shared types and constants for the quoted string unescaper
// Codepoint constants, result codes, phase encoding and the result beat type.
// ----------------------------------------------------------------------------
package qsu_pkg;

    localparam int CpW    = 21;
    localparam int CharW  = 32;
    localparam int KindW  = 2;
    localparam int ErrW   = 3;
    localparam int CountW = 4;
    localparam int ModeW  = 2;
    localparam int OctW   = 9;

    // Characters of interest
    localparam logic [CpW-1:0] CH_DQUOTE = 21'h00022;
    localparam logic [CpW-1:0] CH_SQUOTE = 21'h00027;
    localparam logic [CpW-1:0] CH_BSLASH = 21'h0005C;
    localparam logic [CpW-1:0] CH_LF     = 21'h0000A;
    localparam logic [CpW-1:0] CH_CR     = 21'h0000D;
    localparam logic [CpW-1:0] CH_A      = 21'h00061;
    localparam logic [CpW-1:0] CH_B      = 21'h00062;
    localparam logic [CpW-1:0] CH_F      = 21'h00066;
    localparam logic [CpW-1:0] CH_N      = 21'h0006E;
    localparam logic [CpW-1:0] CH_R      = 21'h00072;
    localparam logic [CpW-1:0] CH_T      = 21'h00074;
    localparam logic [CpW-1:0] CH_V      = 21'h00076;
    localparam logic [CpW-1:0] CH_X      = 21'h00078;
    localparam logic [CpW-1:0] CH_LOW_U  = 21'h00075;
    localparam logic [CpW-1:0] CH_UP_U   = 21'h00055;
    localparam logic [CpW-1:0] CH_OCT_LO = 21'h00030;
    localparam logic [CpW-1:0] CH_OCT_HI = 21'h00037;
    localparam logic [CpW-1:0] CH_DEC_HI = 21'h00039;
    localparam logic [CpW-1:0] CH_LHEX_LO = 21'h00061;
    localparam logic [CpW-1:0] CH_LHEX_HI = 21'h00066;
    localparam logic [CpW-1:0] CH_UHEX_LO = 21'h00041;
    localparam logic [CpW-1:0] CH_UHEX_HI = 21'h00046;

    // Decoded values of the simple escapes
    localparam logic [CharW-1:0] VAL_BEL = 32'h07;
    localparam logic [CharW-1:0] VAL_BS  = 32'h08;
    localparam logic [CharW-1:0] VAL_FF  = 32'h0C;
    localparam logic [CharW-1:0] VAL_LF  = 32'h0A;
    localparam logic [CharW-1:0] VAL_CR  = 32'h0D;
    localparam logic [CharW-1:0] VAL_TAB = 32'h09;
    localparam logic [CharW-1:0] VAL_VT  = 32'h0B;
    localparam logic [CharW-1:0] VAL_BSL = 32'h5C;

    // Digits wanted per hex escape, and the most taken per octal escape
    localparam logic [CountW-1:0] HEX_X_DIGITS  = 4'd2;
    localparam logic [CountW-1:0] HEX_LU_DIGITS = 4'd4;
    localparam logic [CountW-1:0] HEX_UU_DIGITS = 4'd8;
    localparam logic [CountW-1:0] OCT_DIGITS    = 4'd3;

    localparam logic [ModeW-1:0] NEWLINE_MODE_RESET = 2'd1;

    typedef enum logic [KindW-1:0] {
        KIND_CONTENT = 2'd0,
        KIND_CLOSE   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [ErrW-1:0] {
        ERR_NONE  = 3'd0,
        ERR_SHORT = 3'd1,
        ERR_OCT   = 3'd2,
        ERR_HEX_X = 3'd3,
        ERR_HEX_U = 3'd4,
        ERR_HEX_W = 3'd5
    } err_t;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_BODY   = 6'b000010,
        PH_ESC    = 6'b000100,
        PH_ESC_CR = 6'b001000,
        PH_OCT    = 6'b010000,
        PH_HEX    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [CharW-1:0] out_char;
        kind_t            kind;
        err_t             error_code;
        logic             last;
    } beat_t;

    // Build one result beat; last is patched later
    function automatic beat_t mk_beat(input logic [CharW-1:0] ch, input kind_t k,
                                      input err_t e);
        beat_t b;
        b.out_char   = ch;
        b.kind       = k;
        b.error_code = e;
        b.last       = 1'b0;
        return b;
    endfunction

endpackage

[src/quoted_string_unescaper.sv]
// ----------------------------------------------------------------------------
// quoted_string_unescaper: decode the body of quoted string literals
// Per input codepoint, updates the string/escape state and queues 0 to 3
// result beats (content, closing quote or error) toward the output channel.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one codepoint beat with is_open and
//   stream_end flags. Output channel (out_valid/out_ready): one result beat
//   each, last marks the final result of an input beat.
//   Config channel (cfg_valid/cfg_ready): newline_mode, always ready; write
//   it only while the block is idle.
//   Output register: the first result of an input beat is on the output in
//   the cycle after the beat is accepted.
//   Throughput: one input beat per cycle while each beat gives at most one
//   result and out_ready is high. A beat giving more results holds the input:
//   the three-entry result buffer must drain to its last entry before the
//   next beat is accepted.
//   Reset: outside any string, buffer empty, newline_mode = LF only.
//   Stall: when out_ready is low the buffered results hold and in_ready
//   drops once the buffer has any entry that is not being taken.
// ----------------------------------------------------------------------------
module quoted_string_unescaper (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [qsu_pkg::ModeW-1:0]   cfg_data,
    // input codepoints
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [qsu_pkg::CpW-1:0]     codepoint,
    input  logic                        is_open,
    input  logic                        stream_end,
    // results
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [qsu_pkg::CharW-1:0]   out_char,
    output logic [qsu_pkg::KindW-1:0]   kind,
    output logic [qsu_pkg::ErrW-1:0]    error_code,
    output logic                        last
);

    // State registers
    logic [qsu_pkg::ModeW-1:0]  mode_reg;
    qsu_pkg::phase_t            phase_reg, phase_next;
    logic                       raw_reg, raw_next;
    logic                       quote_reg, quote_next;
    logic [qsu_pkg::CountW-1:0] cnt_reg, cnt_next;
    logic [qsu_pkg::CountW-1:0] want_reg, want_next;
    logic [qsu_pkg::CharW-1:0]  val_reg, val_next;

    // Result buffer
    qsu_pkg::beat_t             slot_reg [3];
    qsu_pkg::beat_t             slot_next [3];
    logic [1:0]                 fill_reg, fill_next;

    // Per-beat results
    qsu_pkg::beat_t             res [3];
    logic [1:0]                 nres;
    logic                       err_seen;

    // Helpers
    logic [qsu_pkg::CharW-1:0]  c_ext;
    logic [qsu_pkg::CpW-1:0]    quote_ch;
    logic                       is_oct;
    logic [2:0]                 oct_d;
    logic                       hex_ok;
    logic [3:0]                 hex_d;
    logic [qsu_pkg::CountW-1:0] cnt_inc;
    logic [qsu_pkg::OctW-1:0]   oct_val;
    logic [qsu_pkg::CharW-1:0]  hex_val;
    logic                       do_text;
    logic                       do_pair;

    logic                       in_acc;
    logic                       out_acc;

    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign out_valid = (fill_reg != 2'd0);
    assign in_ready  = (fill_reg == 2'd0) || ((fill_reg == 2'd1) && out_ready);

    assign out_char   = slot_reg[0].out_char;
    assign kind       = slot_reg[0].kind;
    assign error_code = slot_reg[0].error_code;
    assign last       = slot_reg[0].last;

    assign c_ext    = {{(qsu_pkg::CharW - qsu_pkg::CpW){1'b0}}, codepoint};
    assign quote_ch = quote_reg ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
    assign cnt_inc  = cnt_reg + 4'd1;
    assign oct_d    = codepoint[2:0];
    assign oct_val  = {val_reg[5:0], oct_d};
    assign hex_val  = {val_reg[27:0], hex_d};

    // Digit classification
    always_comb
    begin
        is_oct = codepoint inside {[qsu_pkg::CH_OCT_LO:qsu_pkg::CH_OCT_HI]};
        hex_ok = 1'b1;
        hex_d  = codepoint[3:0];
        case (codepoint) inside
            [qsu_pkg::CH_OCT_LO:qsu_pkg::CH_DEC_HI]:   hex_d = codepoint[3:0];
            [qsu_pkg::CH_LHEX_LO:qsu_pkg::CH_LHEX_HI],
            [qsu_pkg::CH_UHEX_LO:qsu_pkg::CH_UHEX_HI]: hex_d = codepoint[3:0] + 4'd9;
            default:
            begin
                hex_ok = 1'b0;
                hex_d  = 4'd0;
            end
        endcase
    end

    // Next state and result list for the beat on the input
    always_comb
    begin
        phase_next = phase_reg;
        raw_next   = raw_reg;
        quote_next = quote_reg;
        cnt_next   = cnt_reg;
        want_next  = want_reg;
        val_next   = val_reg;
        nres       = 2'd0;
        err_seen   = 1'b0;
        do_text    = 1'b0;
        do_pair    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = qsu_pkg::mk_beat('0, qsu_pkg::KIND_CONTENT, qsu_pkg::ERR_NONE);
        end

        if (phase_reg == qsu_pkg::PH_IDLE)
        begin
            // only an opening quote starts a string
            if (!stream_end && is_open &&
                (codepoint == qsu_pkg::CH_DQUOTE || codepoint == qsu_pkg::CH_SQUOTE))
            begin
                quote_next = (codepoint == qsu_pkg::CH_SQUOTE);
                raw_next   = (codepoint == qsu_pkg::CH_SQUOTE);
                phase_next = qsu_pkg::PH_BODY;
            end
        end
        else if (stream_end)
        begin
            // string cut short; flush a pending backslash CR first
            if (phase_reg == qsu_pkg::PH_ESC_CR)
            begin
                res[0] = qsu_pkg::mk_beat(qsu_pkg::VAL_BSL, qsu_pkg::KIND_CONTENT,
                                          qsu_pkg::ERR_NONE);
                res[1] = qsu_pkg::mk_beat(qsu_pkg::VAL_CR, qsu_pkg::KIND_CONTENT,
                                          qsu_pkg::ERR_NONE);
                nres   = 2'd2;
            end
            res[nres]  = qsu_pkg::mk_beat('0, qsu_pkg::KIND_ERROR, qsu_pkg::ERR_SHORT);
            nres       = nres + 2'd1;
            err_seen   = 1'b1;
            phase_next = qsu_pkg::PH_IDLE;
            cnt_next   = '0;
            want_next  = '0;
            val_next   = '0;
        end
        else
        begin
            case (phase_reg)
                qsu_pkg::PH_BODY:
                begin
                    do_text = 1'b1;
                end
                qsu_pkg::PH_ESC:
                begin
                    phase_next = qsu_pkg::PH_BODY;
                    if (raw_reg)
                    begin
                        do_pair = 1'b1;
                    end
                    else
                    begin
                        case (codepoint) inside
                            qsu_pkg::CH_A: res[0].out_char = qsu_pkg::VAL_BEL;
                            qsu_pkg::CH_B: res[0].out_char = qsu_pkg::VAL_BS;
                            qsu_pkg::CH_F: res[0].out_char = qsu_pkg::VAL_FF;
                            qsu_pkg::CH_N: res[0].out_char = qsu_pkg::VAL_LF;
                            qsu_pkg::CH_R: res[0].out_char = qsu_pkg::VAL_CR;
                            qsu_pkg::CH_T: res[0].out_char = qsu_pkg::VAL_TAB;
                            qsu_pkg::CH_V: res[0].out_char = qsu_pkg::VAL_VT;
                            qsu_pkg::CH_BSLASH, qsu_pkg::CH_SQUOTE, qsu_pkg::CH_DQUOTE:
                                res[0].out_char = c_ext;
                            qsu_pkg::CH_X, qsu_pkg::CH_LOW_U, qsu_pkg::CH_UP_U:
                            begin
                                phase_next = qsu_pkg::PH_HEX;
                                cnt_next   = '0;
                                val_next   = '0;
                                if (codepoint == qsu_pkg::CH_X)
                                    want_next = qsu_pkg::HEX_X_DIGITS;
                                else if (codepoint == qsu_pkg::CH_LOW_U)
                                    want_next = qsu_pkg::HEX_LU_DIGITS;
                                else
                                    want_next = qsu_pkg::HEX_UU_DIGITS;
                            end
                            qsu_pkg::CH_LF:
                            begin
                                // escaped LF is dropped when LF line ends are on
                                if (!mode_reg[0])
                                    do_pair = 1'b1;
                            end
                            qsu_pkg::CH_CR:
                            begin
                                if (mode_reg[1])
                                    phase_next = qsu_pkg::PH_ESC_CR;
                                else
                                    do_pair = 1'b1;
                            end
                            [qsu_pkg::CH_OCT_LO:qsu_pkg::CH_OCT_HI]:
                            begin
                                phase_next = qsu_pkg::PH_OCT;
                                cnt_next   = 4'd1;
                                val_next   = {{(qsu_pkg::CharW - 3){1'b0}}, oct_d};
                            end
                            default: do_pair = 1'b1;
                        endcase
                        // simple escapes give one beat already filled in
                        if (!do_pair && phase_next == qsu_pkg::PH_BODY &&
                            !(codepoint == qsu_pkg::CH_LF))
                            nres = 2'd1;
                    end
                end
                qsu_pkg::PH_ESC_CR:
                begin
                    phase_next = qsu_pkg::PH_BODY;
                    if (codepoint != qsu_pkg::CH_LF)
                    begin
                        res[0] = qsu_pkg::mk_beat(qsu_pkg::VAL_BSL, qsu_pkg::KIND_CONTENT,
                                                  qsu_pkg::ERR_NONE);
                        res[1] = qsu_pkg::mk_beat(qsu_pkg::VAL_CR, qsu_pkg::KIND_CONTENT,
                                                  qsu_pkg::ERR_NONE);
                        nres    = 2'd2;
                        do_text = 1'b1;
                    end
                end
                qsu_pkg::PH_OCT:
                begin
                    if (is_oct && cnt_reg < qsu_pkg::OCT_DIGITS)
                    begin
                        val_next = {{(qsu_pkg::CharW - qsu_pkg::OctW){1'b0}}, oct_val};
                        cnt_next = cnt_inc;
                        if (cnt_inc == qsu_pkg::OCT_DIGITS)
                        begin
                            phase_next = (oct_val[8]) ? qsu_pkg::PH_IDLE : qsu_pkg::PH_BODY;
                            cnt_next   = '0;
                            want_next  = '0;
                            val_next   = '0;
                            if (oct_val[8])
                            begin
                                res[0]   = qsu_pkg::mk_beat('0, qsu_pkg::KIND_ERROR,
                                                            qsu_pkg::ERR_OCT);
                                err_seen = 1'b1;
                            end
                            else
                            begin
                                res[0].out_char = {{(qsu_pkg::CharW - qsu_pkg::OctW){1'b0}},
                                                   oct_val};
                            end
                            nres = 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_next  = '0;
                        want_next = '0;
                        val_next  = '0;
                        nres      = 2'd1;
                        if (|val_reg[qsu_pkg::CharW-1:8])
                        begin
                            phase_next = qsu_pkg::PH_IDLE;
                            res[0]     = qsu_pkg::mk_beat('0, qsu_pkg::KIND_ERROR,
                                                          qsu_pkg::ERR_OCT);
                            err_seen   = 1'b1;
                        end
                        else
                        begin
                            phase_next      = qsu_pkg::PH_BODY;
                            res[0].out_char = val_reg;
                            do_text         = 1'b1;
                        end
                    end
                end
                qsu_pkg::PH_HEX:
                begin
                    if (hex_ok && cnt_reg < want_reg)
                    begin
                        val_next = hex_val;
                        cnt_next = cnt_inc;
                        if (cnt_inc == want_reg)
                        begin
                            phase_next      = qsu_pkg::PH_BODY;
                            cnt_next        = '0;
                            want_next       = '0;
                            val_next        = '0;
                            res[0].out_char = hex_val;
                            nres            = 2'd1;
                        end
                    end
                    else if (cnt_reg == want_reg ||
                             (want_reg == qsu_pkg::HEX_X_DIGITS && cnt_reg == 4'd1))
                    begin
                        phase_next      = qsu_pkg::PH_BODY;
                        cnt_next        = '0;
                        want_next       = '0;
                        val_next        = '0;
                        res[0].out_char = val_reg;
                        nres            = 2'd1;
                        do_text         = 1'b1;
                    end
                    else
                    begin
                        phase_next = qsu_pkg::PH_IDLE;
                        cnt_next   = '0;
                        want_next  = '0;
                        val_next   = '0;
                        err_seen   = 1'b1;
                        nres       = 2'd1;
                        if (want_reg == qsu_pkg::HEX_LU_DIGITS)
                            res[0] = qsu_pkg::mk_beat('0, qsu_pkg::KIND_ERROR,
                                                      qsu_pkg::ERR_HEX_U);
                        else if (want_reg == qsu_pkg::HEX_UU_DIGITS)
                            res[0] = qsu_pkg::mk_beat('0, qsu_pkg::KIND_ERROR,
                                                      qsu_pkg::ERR_HEX_W);
                        else
                            res[0] = qsu_pkg::mk_beat('0, qsu_pkg::KIND_ERROR,
                                                      qsu_pkg::ERR_HEX_X);
                    end
                end
                default:
                begin
                    phase_next = qsu_pkg::PH_IDLE;
                    cnt_next   = '0;
                    want_next  = '0;
                    val_next   = '0;
                end
            endcase
        end

        // unknown or raw escape: backslash then the character
        if (do_pair)
        begin
            res[0] = qsu_pkg::mk_beat(qsu_pkg::VAL_BSL, qsu_pkg::KIND_CONTENT,
                                      qsu_pkg::ERR_NONE);
            res[1] = qsu_pkg::mk_beat(c_ext, qsu_pkg::KIND_CONTENT, qsu_pkg::ERR_NONE);
            nres   = 2'd2;
        end

        // plain string text handling of the codepoint
        if (do_text)
        begin
            if (codepoint == qsu_pkg::CH_BSLASH)
            begin
                phase_next = qsu_pkg::PH_ESC;
            end
            else if (codepoint == quote_ch)
            begin
                phase_next = qsu_pkg::PH_IDLE;
                cnt_next   = '0;
                want_next  = '0;
                val_next   = '0;
                res[nres]  = qsu_pkg::mk_beat('0, qsu_pkg::KIND_CLOSE, qsu_pkg::ERR_NONE);
                nres       = nres + 2'd1;
            end
            else
            begin
                res[nres] = qsu_pkg::mk_beat(c_ext, qsu_pkg::KIND_CONTENT, qsu_pkg::ERR_NONE);
                nres      = nres + 2'd1;
            end
        end

        // mark the final beat
        if (nres != 2'd0)
            res[nres - 2'd1].last = 1'b1;
    end

    // Result buffer: load when drained, else shift out one beat per take
    always_comb
    begin
        fill_next = fill_reg;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (in_acc)
        begin
            fill_next = nres;
            for (int i = 0; i < 3; i++)
            begin
                slot_next[i] = res[i];
            end
        end
        else if (out_acc)
        begin
            fill_next    = fill_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= qsu_pkg::NEWLINE_MODE_RESET;
            phase_reg <= qsu_pkg::PH_IDLE;
            raw_reg   <= 1'b0;
            quote_reg <= 1'b0;
            cnt_reg   <= '0;
            want_reg  <= '0;
            val_reg   <= '0;
            fill_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            if (in_acc)
            begin
                phase_reg <= phase_next;
                raw_reg   <= raw_next;
                quote_reg <= quote_next;
                cnt_reg   <= cnt_next;
                want_reg  <= want_next;
                val_reg   <= val_next;
            end
            fill_reg <= fill_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (fill_reg == 2'd0 || (fill_reg == 2'd1 && out_acc)))
        else $error("input beat accepted over undelivered results");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fill_reg == 2'd1) |-> last)
        else $error("final buffered result lacks last");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fill_reg != 2'd1) |-> !last)
        else $error("last set before the final result");

    a_error_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && err_seen) |=> (phase_reg == qsu_pkg::PH_IDLE))
        else $error("not idle after an error");

    a_noncontent_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != qsu_pkg::KIND_CONTENT) |-> (out_char == '0))
        else $error("non-content result carries a character");

endmodule
